// ----- hw/rtl/obb_pkg.sv -----
`default_nettype none

package obb_pkg;

  // Component and derived internal widths.
  localparam int W   = 20;
  localparam int RF  = 18;
  localparam int FW  = 3 * W;
  localparam int DW  = W + 3;
  localparam int TW  = W + 4;
  localparam int RW  = W + 2;
  localparam int AW  = W + 3;
  localparam int CW  = 2 * W + 12;
  localparam int PCW = 2 * W;
  localparam int PTW = DW + W;
  localparam int PAW = W + AW;
  localparam int PRW = TW + RW;

  // Cyclic successor indexes for the cross-product axes.
  localparam int NEXT1 [3] = '{1, 2, 0};
  localparam int NEXT2 [3] = '{2, 0, 1};

  typedef logic [FW-1:0] field_t;

  typedef logic signed [W-1:0] comp_t;
  typedef comp_t [2:0] vec_t;
  typedef vec_t [2:0] mat_t;

  typedef logic signed [DW-1:0] dcomp_t;
  typedef dcomp_t [2:0] dvec_t;

  typedef logic signed [TW-1:0] tcomp_t;
  typedef tcomp_t [2:0] tvec_t;

  typedef logic signed [RW-1:0] rcomp_t;
  typedef rcomp_t [2:0] rrow_t;
  typedef rrow_t [2:0] rmat_t;

  typedef logic signed [AW-1:0] acomp_t;
  typedef acomp_t [2:0] arow_t;
  typedef arow_t [2:0] amat_t;

  typedef logic signed [CW-1:0] acc_t;
  typedef acc_t [2:0] accv_t;
  typedef accv_t [2:0] accm_t;

  // Front-end payload: A's rotation, extents, centre offset, relative rotation, its magnitude.
  typedef struct packed {
    mat_t  ra;
    vec_t  ha;
    vec_t  hb;
    dvec_t d;
    rmat_t r;
    amat_t ar;
  } front_pl_t;

  // Payload leaving the projection stage: offset in A's frame, relative rotation and all radii.
  typedef struct packed {
    tvec_t t;
    rmat_t r;
    accv_t rad_a;
    accv_t rad_b;
    accm_t rad_x;
  } proj_pl_t;

  // Splits a packed field into x, y and z.
  function automatic vec_t unpack(field_t f);
    vec_t v;
    for (int k = 0; k < 3; k++) begin
      v[k] = f[(2 - k) * W +: W];
    end
    return v;
  endfunction

  // Rounds off the rotation fraction, ties upward, then saturates to bits.
  function automatic acc_t rnd_sat(acc_t v, int bits);
    acc_t s;
    acc_t hi;
    acc_t lo;
    s  = (v + (acc_t'(1) <<< (RF - 1))) >>> RF;
    hi = (acc_t'(1) <<< (bits - 1)) - acc_t'(1);
    lo = -hi - acc_t'(1);
    if (s > hi) begin
      s = hi;
    end else if (s < lo) begin
      s = lo;
    end
    return s;
  endfunction

  function automatic acc_t absv(acc_t v);
    return v[CW-1] ? -v : v;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/obb_front.sv -----
`default_nettype none

module obb_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire obb_pkg::field_t   in_a_rot_row0,
  input  wire obb_pkg::field_t   in_a_rot_row1,
  input  wire obb_pkg::field_t   in_a_rot_row2,
  input  wire obb_pkg::field_t   in_a_translation,
  input  wire obb_pkg::field_t   in_a_local_center,
  input  wire obb_pkg::field_t   in_a_extents,
  input  wire obb_pkg::field_t   in_b_rot_row0,
  input  wire obb_pkg::field_t   in_b_rot_row1,
  input  wire obb_pkg::field_t   in_b_rot_row2,
  input  wire obb_pkg::field_t   in_b_translation,
  input  wire obb_pkg::field_t   in_b_local_center,
  input  wire obb_pkg::field_t   in_b_extents,
  output logic                   f_valid,
  output obb_pkg::front_pl_t     f_pl
);
  import obb_pkg::*;

  logic v1_r;
  logic v2_r;

  logic signed [PCW-1:0] pca_r [3][3];
  logic signed [PCW-1:0] pcb_r [3][3];
  logic signed [PCW-1:0] prr_r [3][3][3];
  logic signed [PCW-1:0] pca_nxt [3][3];
  logic signed [PCW-1:0] pcb_nxt [3][3];
  logic signed [PCW-1:0] prr_nxt [3][3][3];
  mat_t ra_r, ra_nxt;
  vec_t ta_r, tb_r, ha_r, hb_r;
  front_pl_t pl_r, pl_nxt;

  // First stage: unpack and form every centre and rotation product.
  always_comb begin
    mat_t rb;
    vec_t ca;
    vec_t cb;
    ra_nxt[0] = unpack(in_a_rot_row0);
    ra_nxt[1] = unpack(in_a_rot_row1);
    ra_nxt[2] = unpack(in_a_rot_row2);
    rb[0] = unpack(in_b_rot_row0);
    rb[1] = unpack(in_b_rot_row1);
    rb[2] = unpack(in_b_rot_row2);
    ca = unpack(in_a_local_center);
    cb = unpack(in_b_local_center);
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        pca_nxt[j][k] = ca[j] * ra_nxt[j][k];
        pcb_nxt[j][k] = cb[j] * rb[j][k];
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          prr_nxt[i][j][k] = ra_nxt[i][k] * rb[j][k];
        end
      end
    end
  end

  // Second stage: world centre difference and relative rotation.
  always_comb begin
    acc_t wa;
    acc_t wb;
    acc_t p;
    rcomp_t rv;
    pl_nxt.ra = ra_r;
    pl_nxt.ha = ha_r;
    pl_nxt.hb = hb_r;
    for (int k = 0; k < 3; k++) begin
      wa = acc_t'(ta_r[k]) <<< RF;
      wb = acc_t'(tb_r[k]) <<< RF;
      for (int j = 0; j < 3; j++) begin
        wa = wa + acc_t'(pca_r[j][k]);
        wb = wb + acc_t'(pcb_r[j][k]);
      end
      pl_nxt.d[k] = DW'(rnd_sat(wb - wa, DW));
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p = '0;
        for (int k = 0; k < 3; k++) begin
          p = p + acc_t'(prr_r[i][j][k]);
        end
        rv = RW'(rnd_sat(p, RW));
        pl_nxt.r[i][j]  = rv;
        pl_nxt.ar[i][j] = rv[RW-1] ? -AW'(rv) : AW'(rv);
      end
    end
  end

  // Valid bits follow the data and hold during a stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pca_r <= pca_nxt;
      pcb_r <= pcb_nxt;
      prr_r <= prr_nxt;
      ra_r  <= ra_nxt;
      ta_r  <= unpack(in_a_translation);
      tb_r  <= unpack(in_b_translation);
      ha_r  <= unpack(in_a_extents);
      hb_r  <= unpack(in_b_extents);
      pl_r  <= pl_nxt;
    end
  end

  assign f_valid = v2_r;
  assign f_pl    = pl_r;

endmodule

`default_nettype wire

// ----- hw/rtl/obb_proj.sv -----
`default_nettype none

module obb_proj (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               f_valid,
  input  wire obb_pkg::front_pl_t f_pl,
  output logic                    p_valid,
  output obb_pkg::proj_pl_t       p_pl
);
  import obb_pkg::*;

  logic v3_r;
  logic v4_r;

  logic signed [PTW-1:0] pt_r [3][3];
  logic signed [PAW-1:0] pa_r [3][3][3];
  logic signed [PAW-1:0] pb_r [3][3][3];
  logic signed [PTW-1:0] pt_nxt [3][3];
  logic signed [PAW-1:0] pa_nxt [3][3][3];
  logic signed [PAW-1:0] pb_nxt [3][3][3];
  rmat_t r_r;
  vec_t ha_r, hb_r;
  proj_pl_t pl_r, pl_nxt;

  // Third stage: offset products and every extent times rotation product.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        pt_nxt[i][k] = f_pl.d[k] * f_pl.ra[i][k];
      end
    end
    for (int a = 0; a < 3; a++) begin
      for (int c = 0; c < 3; c++) begin
        for (int j = 0; j < 3; j++) begin
          pa_nxt[a][c][j] = f_pl.ha[a] * f_pl.ar[c][j];
          pb_nxt[a][c][j] = f_pl.hb[a] * f_pl.ar[c][j];
        end
      end
    end
  end

  // Fourth stage: offset in A's frame and the radii of all fifteen axes.
  always_comb begin
    acc_t s;
    pl_nxt.r = r_r;
    for (int i = 0; i < 3; i++) begin
      s = '0;
      for (int k = 0; k < 3; k++) begin
        s = s + acc_t'(pt_r[i][k]);
      end
      pl_nxt.t[i] = TW'(rnd_sat(s, TW));
    end
    for (int i = 0; i < 3; i++) begin
      s = acc_t'(ha_r[i]) <<< RF;
      for (int j = 0; j < 3; j++) begin
        s = s + acc_t'(pb_r[j][i][j]);
      end
      pl_nxt.rad_a[i] = s;
    end
    for (int j = 0; j < 3; j++) begin
      s = acc_t'(hb_r[j]) <<< RF;
      for (int i = 0; i < 3; i++) begin
        s = s + acc_t'(pa_r[i][i][j]);
      end
      pl_nxt.rad_b[j] = s;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pl_nxt.rad_x[i][j] = acc_t'(pa_r[NEXT1[i]][NEXT2[i]][j])
                           + acc_t'(pa_r[NEXT2[i]][NEXT1[i]][j])
                           + acc_t'(pb_r[NEXT1[j]][i][NEXT2[j]])
                           + acc_t'(pb_r[NEXT2[j]][i][NEXT1[j]]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v3_r <= f_valid;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt_r <= pt_nxt;
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
      r_r  <= f_pl.r;
      ha_r <= f_pl.ha;
      hb_r <= f_pl.hb;
      pl_r <= pl_nxt;
    end
  end

  assign p_valid = v4_r;
  assign p_pl    = pl_r;

endmodule

`default_nettype wire

// ----- hw/rtl/obb_sep.sv -----
`default_nettype none

module obb_sep (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              p_valid,
  input  wire obb_pkg::proj_pl_t p_pl,
  output logic                   s_valid,
  output logic                   s_overlap
);
  import obb_pkg::*;

  logic v5_r;
  logic sep_a_r, sep_a_nxt;
  logic signed [PRW-1:0] ptr_r [3][3][3];
  logic signed [PRW-1:0] ptr_nxt [3][3][3];
  accv_t rad_b_r;
  accm_t rad_x_r;

  // Fifth stage: offset times rotation products, and the axes of A.
  always_comb begin
    sep_a_nxt = 1'b0;
    for (int a = 0; a < 3; a++) begin
      for (int c = 0; c < 3; c++) begin
        for (int j = 0; j < 3; j++) begin
          ptr_nxt[a][c][j] = p_pl.t[a] * p_pl.r[c][j];
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (absv(acc_t'(p_pl.t[i]) <<< RF) > p_pl.rad_a[i]) begin
        sep_a_nxt = 1'b1;
      end
    end
  end

  // Sixth stage: projections on the axes of B and the cross axes.
  always_comb begin
    acc_t pj;
    logic sep;
    sep = sep_a_r;
    for (int j = 0; j < 3; j++) begin
      pj = '0;
      for (int i = 0; i < 3; i++) begin
        pj = pj + acc_t'(ptr_r[i][i][j]);
      end
      if (absv(pj) > rad_b_r[j]) begin
        sep = 1'b1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pj = acc_t'(ptr_r[NEXT2[i]][NEXT1[i]][j]) - acc_t'(ptr_r[NEXT1[i]][NEXT2[i]][j]);
        if (absv(pj) > rad_x_r[i][j]) begin
          sep = 1'b1;
        end
      end
    end
    s_overlap = !sep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ptr_r   <= ptr_nxt;
      sep_a_r <= sep_a_nxt;
      rad_b_r <= p_pl.rad_b;
      rad_x_r <= p_pl.rad_x;
    end
  end

  assign s_valid = v5_r;

endmodule

`default_nettype wire

// ----- hw/rtl/obb_pair_overlap_test.sv -----
`default_nettype none

// Channel   Ports                                  Moves
// input     in_valid, in_ready, in_a_*, in_b_*     one item: a pair of boxes
// result    out_valid, out_ready, out_boxes_overlap one item: overlap flag
//
// Six register stages: two each in front and proj, one in sep, and the output register.
// One item can be accepted every cycle unless the pipeline stalls; no stage is ever busy.
// Reset is synchronous and clears only the valid bits.
// When a result waits with out_ready low the whole pipeline holds and in_ready falls.

module obb_pair_overlap_test (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire obb_pkg::field_t  in_a_rot_row0,
  input  wire obb_pkg::field_t  in_a_rot_row1,
  input  wire obb_pkg::field_t  in_a_rot_row2,
  input  wire obb_pkg::field_t  in_a_translation,
  input  wire obb_pkg::field_t  in_a_local_center,
  input  wire obb_pkg::field_t  in_a_extents,
  input  wire obb_pkg::field_t  in_b_rot_row0,
  input  wire obb_pkg::field_t  in_b_rot_row1,
  input  wire obb_pkg::field_t  in_b_rot_row2,
  input  wire obb_pkg::field_t  in_b_translation,
  input  wire obb_pkg::field_t  in_b_local_center,
  input  wire obb_pkg::field_t  in_b_extents,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_boxes_overlap
);
  import obb_pkg::*;

  logic      en;
  logic      f_valid;
  front_pl_t f_pl;
  logic      p_valid;
  proj_pl_t  p_pl;
  logic      s_valid;
  logic      s_overlap;
  logic      out_valid_r;
  logic      out_overlap_r;

  // The pipeline advances whenever the output register is free or being taken.
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  obb_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .en                (en),
    .in_valid          (in_valid),
    .in_a_rot_row0     (in_a_rot_row0),
    .in_a_rot_row1     (in_a_rot_row1),
    .in_a_rot_row2     (in_a_rot_row2),
    .in_a_translation  (in_a_translation),
    .in_a_local_center (in_a_local_center),
    .in_a_extents      (in_a_extents),
    .in_b_rot_row0     (in_b_rot_row0),
    .in_b_rot_row1     (in_b_rot_row1),
    .in_b_rot_row2     (in_b_rot_row2),
    .in_b_translation  (in_b_translation),
    .in_b_local_center (in_b_local_center),
    .in_b_extents      (in_b_extents),
    .f_valid           (f_valid),
    .f_pl              (f_pl)
  );

  obb_proj u_proj (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .f_valid (f_valid),
    .f_pl    (f_pl),
    .p_valid (p_valid),
    .p_pl    (p_pl)
  );

  obb_sep u_sep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .p_valid   (p_valid),
    .p_pl      (p_pl),
    .s_valid   (s_valid),
    .s_overlap (s_overlap)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_overlap_r <= s_overlap;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_boxes_overlap = out_overlap_r;

  // A stall freezes the valid bits of the front, projection and separation stages and the output.
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> $stable({f_valid, p_valid, s_valid, out_valid_r}))
    else $error("pipeline valid bits moved during a stall");

  // A waiting result is not dropped.
  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_overlap_r))
    else $error("waiting result lost or changed");

  // A valid item in the last stage reaches the output when the pipeline moves.
  a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s_valid && en |=> out_valid_r)
    else $error("item lost between last stage and output register");

endmodule

`default_nettype wire
